// ===== hw/rtl/atms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA timing mode select package
// Shared widths, status codes, reset values and the timing tables used by the
// per-unit timing selector.
// ----------------------------------------------------------------------------
package atms_pkg;

    localparam int UNITS       = 2;
    localparam int PIO_ENTRIES = 11;
    localparam int DMA_ENTRIES = 9;

    localparam int UNIT_W  = 2;
    localparam int UIDX_W  = $clog2(UNITS);
    localparam int IDX_W   = $clog2((PIO_ENTRIES > DMA_ENTRIES) ? PIO_ENTRIES : DMA_ENTRIES);
    localparam int MAP_W   = 16;
    localparam int NS_W    = 16;
    localparam int TIM_W   = 22;
    localparam int PKT_W   = 8;
    localparam int STAT_W  = 2;
    localparam int PMODE_W = 3;
    localparam int DMODE_W = 2;

    typedef logic [MAP_W-1:0]  map_t;
    typedef logic [NS_W-1:0]   ns_t;
    typedef logic [TIM_W-1:0]  timing_t;
    typedef logic [PKT_W-1:0]  pkt_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_BAD_PARAM   = 2'd1;
    localparam status_t ST_UNSUPPORTED = 2'd2;

    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam map_t PIO_SUPPORTED = 16'h001F;
    localparam map_t DMA_SUPPORTED = 16'h0007;

    localparam timing_t RST_TIMING    = 22'h074526;
    localparam map_t    RST_PIO_MODE  = 16'd1;
    localparam ns_t     RST_PIO_CYCLE = 16'd600;
    localparam map_t    RST_DMA_MODE  = 16'd1;
    localparam ns_t     RST_DMA_CYCLE = 16'd480;
    localparam pkt_t    RST_PACKET    = 8'd0;

    function automatic ns_t pio_min_cycle(input logic [PMODE_W-1:0] mode);
        ns_t r;
        case (mode)
            3'd0:    r = 16'd600;
            3'd1:    r = 16'd383;
            3'd2:    r = 16'd240;
            3'd3:    r = 16'd180;
            3'd4:    r = 16'd120;
            default: r = 16'd600;
        endcase
        return r;
    endfunction

    function automatic ns_t dma_min_cycle(input logic [DMODE_W-1:0] mode);
        ns_t r;
        case (mode)
            2'd0:    r = 16'd480;
            2'd1:    r = 16'd150;
            2'd2:    r = 16'd120;
            default: r = 16'd480;
        endcase
        return r;
    endfunction

    function automatic ns_t pio_tbl_ns(input idx_t idx);
        ns_t r;
        case (idx)
            4'd0:    r = 16'd2070;
            4'd1:    r = 16'd600;
            4'd2:    r = 16'd383;
            4'd3:    r = 16'd360;
            4'd4:    r = 16'd330;
            4'd5:    r = 16'd300;
            4'd6:    r = 16'd270;
            4'd7:    r = 16'd240;
            4'd8:    r = 16'd239;
            4'd9:    r = 16'd180;
            4'd10:   r = 16'd120;
            default: r = 16'd2070;
        endcase
        return r;
    endfunction

    function automatic timing_t pio_reg_val(input idx_t idx);
        timing_t r;
        case (idx)
            4'd0:    r = 22'h000400;
            4'd1:    r = 22'h000526;
            4'd2:    r = 22'h000085;
            4'd3:    r = 22'h000046;
            4'd4:    r = 22'h000045;
            default: r = 22'h000025;
        endcase
        return r;
    endfunction

    function automatic ns_t dma_tbl_ns(input idx_t idx);
        ns_t r;
        case (idx)
            4'd0:    r = 16'd1950;
            4'd1:    r = 16'd480;
            4'd2:    r = 16'd360;
            4'd3:    r = 16'd270;
            4'd4:    r = 16'd240;
            4'd5:    r = 16'd210;
            4'd6:    r = 16'd180;
            4'd7:    r = 16'd150;
            4'd8:    r = 16'd120;
            default: r = 16'd1950;
        endcase
        return r;
    endfunction

    function automatic timing_t dma_reg_val(input idx_t idx);
        timing_t r;
        case (idx)
            4'd0:    r = 22'h000000;
            4'd1:    r = 22'h074000;
            4'd2:    r = 22'h053000;
            4'd3:    r = 22'h242000;
            4'd4:    r = 22'h032000;
            4'd5:    r = 22'h231800;
            4'd6:    r = 22'h021800;
            4'd7:    r = 22'h221000;
            4'd8:    r = 22'h211000;
            default: r = 22'h000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ata_timing_mode_select_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA timing mode select core
// Per-unit PIO and multiword DMA timing selection for two drive units, with
// read-back of the stored settings.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the response has been shown. The response appears on the result ports
// for exactly one cycle with done high and must be captured then, since the
// block cannot be stalled. A read or a rejected request goes from S_CHECK to
// S_RESP; a full select passes through the clamp and scan states, using the
// single shared cycle-time comparator that first clamps both cycle times and
// then walks the PIO table (up to 11 entries) and the DMA table (up to 9
// entries), one entry per cycle, fastest entry first.
// ----------------------------------------------------------------------------
module ata_timing_mode_select_core (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    output logic                             done,
    input  wire                              kind,
    input  wire  [atms_pkg::UNIT_W-1:0]      unit,
    input  wire  [atms_pkg::MAP_W-1:0]       pio_mode_bits,
    input  wire  [atms_pkg::MAP_W-1:0]       dma_mode_bits,
    input  wire  [atms_pkg::MAP_W-1:0]       ultra_mode_bits,
    input  wire  [atms_pkg::NS_W-1:0]        pio_cycle_ns,
    input  wire  [atms_pkg::NS_W-1:0]        dma_cycle_ns,
    input  wire  [atms_pkg::PKT_W-1:0]       packet_setting,
    output logic [atms_pkg::STAT_W-1:0]      status,
    output logic [atms_pkg::TIM_W-1:0]       timing_word,
    output logic [atms_pkg::MAP_W-1:0]       pio_mode_out,
    output logic [atms_pkg::NS_W-1:0]        pio_cycle_out,
    output logic [atms_pkg::MAP_W-1:0]       dma_mode_out,
    output logic [atms_pkg::NS_W-1:0]        dma_cycle_out,
    output logic [atms_pkg::PKT_W-1:0]       packet_out
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_CLAMP_P = 3'd2;
    localparam logic [2:0] S_CLAMP_D = 3'd3;
    localparam logic [2:0] S_SCAN_P  = 3'd4;
    localparam logic [2:0] S_SCAN_D  = 3'd5;
    localparam logic [2:0] S_RESP    = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic                        kind_reg;
    logic [atms_pkg::UNIT_W-1:0] unit_reg;
    atms_pkg::map_t              pio_reg, dma_reg;
    logic                        ultra_reg;
    atms_pkg::ns_t               pcyc_reg, pcyc_next;
    atms_pkg::ns_t               dcyc_reg, dcyc_next;
    atms_pkg::pkt_t              pkt_reg;
    atms_pkg::idx_t              idx_reg, idx_next;
    atms_pkg::timing_t           pbits_reg, pbits_next;
    atms_pkg::status_t           status_reg, status_next;

    atms_pkg::timing_t timing_mem_reg    [atms_pkg::UNITS];
    atms_pkg::map_t    pio_mode_mem_reg  [atms_pkg::UNITS];
    atms_pkg::ns_t     pio_cycle_mem_reg [atms_pkg::UNITS];
    atms_pkg::map_t    dma_mode_mem_reg  [atms_pkg::UNITS];
    atms_pkg::ns_t     dma_cycle_mem_reg [atms_pkg::UNITS];
    atms_pkg::pkt_t    packet_mem_reg    [atms_pkg::UNITS];

    logic                              accept;
    logic [atms_pkg::UIDX_W-1:0]       uidx;
    logic [atms_pkg::PMODE_W-1:0]      pmode;
    logic [atms_pkg::DMODE_W-1:0]      dmode;
    atms_pkg::ns_t                     cmp_a, cmp_b;
    logic                              cmp_le;
    logic                              pkt_we;
    logic                              set_we;
    atms_pkg::timing_t                 timing_wdata;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_RESP);
    assign uidx   = unit_reg[atms_pkg::UIDX_W-1:0];

    always_comb
    begin
        if (pio_reg[4])
            pmode = 3'd4;
        else if (pio_reg[3])
            pmode = 3'd3;
        else if (pio_reg[2])
            pmode = 3'd2;
        else if (pio_reg[1])
            pmode = 3'd1;
        else
            pmode = 3'd0;

        if (dma_reg[2])
            dmode = 2'd2;
        else if (dma_reg[1])
            dmode = 2'd1;
        else
            dmode = 2'd0;
    end

    always_comb
    begin
        unique case (state_reg)
            S_CLAMP_P:
            begin
                cmp_a = atms_pkg::pio_min_cycle(pmode);
                cmp_b = pcyc_reg;
            end
            S_CLAMP_D:
            begin
                cmp_a = atms_pkg::dma_min_cycle(dmode);
                cmp_b = dcyc_reg;
            end
            S_SCAN_P:
            begin
                cmp_a = pcyc_reg;
                cmp_b = atms_pkg::pio_tbl_ns(idx_reg);
            end
            S_SCAN_D:
            begin
                cmp_a = dcyc_reg;
                cmp_b = atms_pkg::dma_tbl_ns(idx_reg);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_le = (cmp_a <= cmp_b);

    always_comb
    begin
        state_next   = state_reg;
        pcyc_next    = pcyc_reg;
        dcyc_next    = dcyc_reg;
        idx_next     = idx_reg;
        pbits_next   = pbits_reg;
        status_next  = status_reg;
        pkt_we       = 1'b0;
        set_we       = 1'b0;
        timing_wdata = pbits_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pcyc_next  = pio_cycle_ns;
                    dcyc_next  = dma_cycle_ns;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next  = S_RESP;
                status_next = atms_pkg::ST_OK;
                if (unit_reg > atms_pkg::UNIT_W'(atms_pkg::UNITS - 1))
                    status_next = atms_pkg::ST_BAD_PARAM;
                else if (kind_reg == atms_pkg::KIND_SELECT)
                begin
                    if (ultra_reg || ((pio_reg & atms_pkg::PIO_SUPPORTED) == '0) ||
                        ((dma_reg & ~atms_pkg::DMA_SUPPORTED) != '0))
                        status_next = atms_pkg::ST_UNSUPPORTED;
                    else
                    begin
                        pkt_we = 1'b1;
                        if ((pio_reg & ~atms_pkg::PIO_SUPPORTED) != '0)
                            status_next = atms_pkg::ST_UNSUPPORTED;
                        else
                            state_next = S_CLAMP_P;
                    end
                end
            end
            S_CLAMP_P:
            begin
                if (!cmp_le)
                    pcyc_next = cmp_a;
                state_next = S_CLAMP_D;
            end
            S_CLAMP_D:
            begin
                if (!cmp_le)
                    dcyc_next = cmp_a;
                idx_next   = atms_pkg::IDX_W'(atms_pkg::PIO_ENTRIES - 1);
                state_next = S_SCAN_P;
            end
            S_SCAN_P:
            begin
                if (cmp_le || (idx_reg == '0))
                begin
                    pbits_next = atms_pkg::pio_reg_val(cmp_le ? idx_reg : '0);
                    idx_next   = atms_pkg::IDX_W'(atms_pkg::DMA_ENTRIES - 1);
                    state_next = S_SCAN_D;
                end
                else
                    idx_next = idx_reg - 1'b1;
            end
            S_SCAN_D:
            begin
                if (cmp_le || (idx_reg == '0))
                begin
                    timing_wdata = pbits_reg | atms_pkg::dma_reg_val(cmp_le ? idx_reg : '0);
                    set_we       = 1'b1;
                    state_next   = S_RESP;
                end
                else
                    idx_next = idx_reg - 1'b1;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            unit_reg  <= unit;
            pio_reg   <= pio_mode_bits;
            dma_reg   <= dma_mode_bits;
            ultra_reg <= (ultra_mode_bits != '0);
            pkt_reg   <= packet_setting;
        end
        pcyc_reg   <= pcyc_next;
        dcyc_reg   <= dcyc_next;
        idx_reg    <= idx_next;
        pbits_reg  <= pbits_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < atms_pkg::UNITS; u++)
            begin
                timing_mem_reg[u]    <= atms_pkg::RST_TIMING;
                pio_mode_mem_reg[u]  <= atms_pkg::RST_PIO_MODE;
                pio_cycle_mem_reg[u] <= atms_pkg::RST_PIO_CYCLE;
                dma_mode_mem_reg[u]  <= atms_pkg::RST_DMA_MODE;
                dma_cycle_mem_reg[u] <= atms_pkg::RST_DMA_CYCLE;
                packet_mem_reg[u]    <= atms_pkg::RST_PACKET;
            end
        end
        else
        begin
            if (pkt_we)
                packet_mem_reg[uidx] <= pkt_reg;
            if (set_we)
            begin
                timing_mem_reg[uidx]    <= timing_wdata;
                pio_mode_mem_reg[uidx]  <= pio_reg;
                pio_cycle_mem_reg[uidx] <= pcyc_reg;
                dma_mode_mem_reg[uidx]  <= dma_reg;
                dma_cycle_mem_reg[uidx] <= dcyc_reg;
            end
        end
    end

    always_comb
    begin
        status = status_reg;
        if (status_reg == atms_pkg::ST_OK)
        begin
            timing_word   = timing_mem_reg[uidx];
            pio_mode_out  = pio_mode_mem_reg[uidx];
            pio_cycle_out = pio_cycle_mem_reg[uidx];
            dma_mode_out  = dma_mode_mem_reg[uidx];
            dma_cycle_out = dma_cycle_mem_reg[uidx];
            packet_out    = packet_mem_reg[uidx];
        end
        else
        begin
            timing_word   = '0;
            pio_mode_out  = '0;
            pio_cycle_out = '0;
            dma_mode_out  = '0;
            dma_cycle_out = '0;
            packet_out    = '0;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted request did not start work");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block stayed busy after its response");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != atms_pkg::ST_OK) |-> (timing_word == '0) && (packet_out == '0))
        else $error("error response carries stored data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == atms_pkg::ST_OK) || (status == atms_pkg::ST_BAD_PARAM) ||
                 (status == atms_pkg::ST_UNSUPPORTED))
        else $error("undefined status code in response");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_P) |-> (idx_reg <= atms_pkg::IDX_W'(atms_pkg::PIO_ENTRIES - 1)))
        else $error("PIO table index out of range");

endmodule
`default_nettype wire
